### rtl/ipv4hp_pkg.sv
package ipv4hp_pkg;

    // Byte counter width (saturating)
    localparam int COUNT_BITS_DEF = 17;

    // Offset register
    localparam int          OFFSET_W     = 8;
    localparam logic [7:0]  OFFSET_RESET = 8'd14;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 144;

    // Header layout
    localparam int HDR_MIN_BYTES = 20;
    localparam int HDR_MIN_WORDS = 5;
    localparam logic [3:0] IP_VERSION_4 = 4'd4;

    // Protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_NOT_V4     = 3'd2,
        ST_BAD_IHL    = 3'd3,
        ST_INCOMPLETE = 3'd4,
        ST_BAD_LENGTH = 3'd5,
        ST_FRAGMENTED = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PC_OTHER = 2'd0,
        PC_ICMP  = 2'd1,
        PC_TCP   = 2'd2,
        PC_UDP   = 2'd3
    } proto_class_t;

    // Result word, first member listed is the highest bits
    typedef struct packed {
        logic [2:0]   pad;
        logic [15:0]  received_checksum;
        logic [31:0]  dest_addr;
        logic [31:0]  source_addr;
        proto_class_t protocol_class;
        logic [7:0]   protocol_number;
        logic [7:0]   time_to_live;
        logic [2:0]   flag_bits;
        logic [15:0]  identification;
        logic [15:0]  total_length;
        logic [3:0]   header_words;
        logic         checksum_ok;
        status_t      status;
    } result_t;

    function automatic proto_class_t class_of(input logic [7:0] p);
        proto_class_t c;
        case (p)
            PROTO_ICMP: c = PC_ICMP;
            PROTO_TCP:  c = PC_TCP;
            PROTO_UDP:  c = PC_UDP;
            default:    c = PC_OTHER;
        endcase
        return c;
    endfunction

endpackage

### rtl/ipv4_header_parser_core.sv
// A byte accepted into the byte stage is processed when that stage advances; the result
// of a packet is loaded into the result register as its last byte leaves the byte stage.
// Throughput: one byte per cycle; the byte stage only waits when its byte
// is a last byte and the result register is still held by the sink.
// Reset (aresetn low, synchronous): clears all packet state and both valid flags,
// and loads ip_offset with 14.
module ipv4_header_parser_core #(
    parameter int COUNT_BITS = ipv4hp_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: ip_offset
    input  logic                               cfg_wr_en,
    input  logic [ipv4hp_pkg::OFFSET_W-1:0]    cfg_wr_data,
    // byte stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ipv4hp_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // last_byte
    // result out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata, from bit 0 up: status[2:0], checksum_ok[3], header_words[7:4],
    // total_length[23:8], identification[39:24], flag_bits[42:40],
    // time_to_live[50:43], protocol_number[58:51], protocol_class[60:59],
    // source_addr[92:61], dest_addr[124:93], received_checksum[140:125],
    // zero pad[143:141]
    output logic [ipv4hp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int CW = COUNT_BITS;
    // width that holds both the 16-bit length field and a byte count
    localparam int LW = (CW > 16) ? CW : 16;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [7:0] ip_offset_reg;

    // ---------------------------------------------------------------
    // Input word register
    // ---------------------------------------------------------------
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;

    // ---------------------------------------------------------------
    // Packet state
    // ---------------------------------------------------------------
    logic [CW-1:0] byte_count_reg,     byte_count_next;
    logic [15:0]   sum_accum_reg,      sum_accum_next;
    logic [7:0]    pending_high_reg,   pending_high_next;
    logic [7:0]    version_ihl_reg,    version_ihl_next;
    logic [15:0]   length_field_reg,   length_field_next;
    logic [15:0]   ident_field_reg,    ident_field_next;
    logic [15:0]   flags_offset_reg,   flags_offset_next;
    logic [7:0]    ttl_field_reg,      ttl_field_next;
    logic [7:0]    proto_field_reg,    proto_field_next;
    logic [15:0]   checksum_field_reg, checksum_field_next;
    logic [31:0]   src_field_reg,      src_field_next;
    logic [31:0]   dst_field_reg,      dst_field_next;

    // Result register
    logic                  out_vld_reg;
    ipv4hp_pkg::result_t   out_reg;
    ipv4hp_pkg::result_t   result;

    // Byte position relative to the header
    logic [CW-1:0] offset_ext;
    logic [CW-1:0] rel;
    logic          in_header;
    logic          in_hdr20;
    logic [3:0]    words;
    logic          in_sum;
    logic [16:0]   sum_wide;
    logic [15:0]   sum_fold;

    // Final checks
    logic [CW-1:0] need_min;
    logic [CW-1:0] need_hdr;
    logic [CW-1:0] avail;
    logic          too_short;
    logic          too_long;
    logic          fragmented;
    ipv4hp_pkg::status_t status;

    // Drain the byte stage unless it holds a last byte and the result
    // register is still full and stalled.
    assign advance  = in_vld_reg && (!in_last_reg || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // ---------------------------------------------------------------
    // Per-byte update
    // ---------------------------------------------------------------
    assign offset_ext = CW'(ip_offset_reg);
    assign rel        = byte_count_reg - offset_ext;
    assign in_header  = (byte_count_reg != CMAX) && (byte_count_reg >= offset_ext);
    assign in_hdr20   = in_header && (rel < CW'(ipv4hp_pkg::HDR_MIN_BYTES));

    always_comb begin
        version_ihl_next    = version_ihl_reg;
        length_field_next   = length_field_reg;
        ident_field_next    = ident_field_reg;
        flags_offset_next   = flags_offset_reg;
        ttl_field_next      = ttl_field_reg;
        proto_field_next    = proto_field_reg;
        checksum_field_next = checksum_field_reg;
        src_field_next      = src_field_reg;
        dst_field_next      = dst_field_reg;
        if (in_hdr20) begin
            case (rel[4:0])
                5'd0:         version_ihl_next    = in_byte_reg;
                5'd2, 5'd3:   length_field_next   = {length_field_reg[7:0], in_byte_reg};
                5'd4, 5'd5:   ident_field_next    = {ident_field_reg[7:0], in_byte_reg};
                5'd6, 5'd7:   flags_offset_next   = {flags_offset_reg[7:0], in_byte_reg};
                5'd8:         ttl_field_next      = in_byte_reg;
                5'd9:         proto_field_next    = in_byte_reg;
                5'd10, 5'd11: checksum_field_next = {checksum_field_reg[7:0], in_byte_reg};
                5'd12, 5'd13, 5'd14, 5'd15:
                              src_field_next      = {src_field_reg[23:0], in_byte_reg};
                5'd16, 5'd17, 5'd18, 5'd19:
                              dst_field_next      = {dst_field_reg[23:0], in_byte_reg};
                default: ;
            endcase
        end
    end

    // Checksum over 4*IHL bytes, IHL taken after this byte's capture
    assign words    = version_ihl_next[3:0];
    assign in_sum   = in_header && (rel < CW'({words, 2'b00}));
    assign sum_wide = {1'b0, sum_accum_reg} + {1'b0, pending_high_reg, in_byte_reg};
    // fold the end-around carry
    assign sum_fold = sum_wide[15:0] + 16'(sum_wide[16]);

    always_comb begin
        pending_high_next = pending_high_reg;
        sum_accum_next    = sum_accum_reg;
        if (in_sum) begin
            if (!rel[0]) begin
                pending_high_next = in_byte_reg;
            end else begin
                sum_accum_next = sum_fold;
            end
        end
    end

    // saturate at all ones
    assign byte_count_next = (byte_count_reg != CMAX) ? byte_count_reg + CW'(1)
                                                      : byte_count_reg;

    // ---------------------------------------------------------------
    // End-of-packet checks, on the state after the last byte
    // ---------------------------------------------------------------
    assign need_min   = offset_ext + CW'(ipv4hp_pkg::HDR_MIN_BYTES);
    assign need_hdr   = offset_ext + CW'({words, 2'b00});
    assign avail      = byte_count_next - offset_ext;
    assign too_short  = byte_count_next < need_min;
    assign too_long   = LW'(length_field_next) > LW'(avail);
    assign fragmented = flags_offset_next[13] || (flags_offset_next[12:0] != 13'd0);

    always_comb begin
        if (too_short) begin
            status = ipv4hp_pkg::ST_SHORT;
        end else if (version_ihl_next[7:4] != ipv4hp_pkg::IP_VERSION_4) begin
            status = ipv4hp_pkg::ST_NOT_V4;
        end else if (words < 4'(ipv4hp_pkg::HDR_MIN_WORDS)) begin
            status = ipv4hp_pkg::ST_BAD_IHL;
        end else if (byte_count_next < need_hdr) begin
            status = ipv4hp_pkg::ST_INCOMPLETE;
        end else if (too_long) begin
            status = ipv4hp_pkg::ST_BAD_LENGTH;
        end else if (fragmented) begin
            status = ipv4hp_pkg::ST_FRAGMENTED;
        end else begin
            status = ipv4hp_pkg::ST_OK;
        end
    end

    always_comb begin
        result        = '0;
        result.status = status;
        // early rejects carry only the status
        if (status == ipv4hp_pkg::ST_OK || status == ipv4hp_pkg::ST_BAD_LENGTH ||
            status == ipv4hp_pkg::ST_FRAGMENTED) begin
            result.checksum_ok       = (sum_accum_next == 16'hFFFF);
            result.header_words      = words;
            result.total_length      = length_field_next;
            result.identification    = ident_field_next;
            result.flag_bits         = flags_offset_next[15:13];
            result.time_to_live      = ttl_field_next;
            result.protocol_number   = proto_field_next;
            result.protocol_class    = ipv4hp_pkg::class_of(proto_field_next);
            result.source_addr       = src_field_next;
            result.dest_addr         = dst_field_next;
            result.received_checksum = checksum_field_next;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_offset_reg      <= ipv4hp_pkg::OFFSET_RESET;
            in_vld_reg         <= 1'b0;
            out_vld_reg        <= 1'b0;
            byte_count_reg     <= '0;
            sum_accum_reg      <= '0;
            pending_high_reg   <= '0;
            version_ihl_reg    <= '0;
            length_field_reg   <= '0;
            ident_field_reg    <= '0;
            flags_offset_reg   <= '0;
            ttl_field_reg      <= '0;
            proto_field_reg    <= '0;
            checksum_field_reg <= '0;
            src_field_reg      <= '0;
            dst_field_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                ip_offset_reg <= cfg_wr_data;
            end

            // byte stage: load on accept, empty when drained
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end

            // result stage: load on last byte, drop when taken
            if (advance && in_last_reg) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end

            if (advance) begin
                if (in_last_reg) begin
                    // clear packet state for the next packet
                    byte_count_reg     <= '0;
                    sum_accum_reg      <= '0;
                    pending_high_reg   <= '0;
                    version_ihl_reg    <= '0;
                    length_field_reg   <= '0;
                    ident_field_reg    <= '0;
                    flags_offset_reg   <= '0;
                    ttl_field_reg      <= '0;
                    proto_field_reg    <= '0;
                    checksum_field_reg <= '0;
                    src_field_reg      <= '0;
                    dst_field_reg      <= '0;
                end else begin
                    byte_count_reg     <= byte_count_next;
                    sum_accum_reg      <= sum_accum_next;
                    pending_high_reg   <= pending_high_next;
                    version_ihl_reg    <= version_ihl_next;
                    length_field_reg   <= length_field_next;
                    ident_field_reg    <= ident_field_next;
                    flags_offset_reg   <= flags_offset_next;
                    ttl_field_reg      <= ttl_field_next;
                    proto_field_reg    <= proto_field_next;
                    checksum_field_reg <= checksum_field_next;
                    src_field_reg      <= src_field_next;
                    dst_field_reg      <= dst_field_next;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_reg <= result;
        end
    end

endmodule

### rtl/ipv4hp_checker.sv
module ipv4hp_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tlast,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ipv4hp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    // Early rejects carry nothing but the status.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ipv4hp_pkg::ST_SHORT ||
                     m_tdata[2:0] == ipv4hp_pkg::ST_NOT_V4 ||
                     m_tdata[2:0] == ipv4hp_pkg::ST_BAD_IHL ||
                     m_tdata[2:0] == ipv4hp_pkg::ST_INCOMPLETE)
        |-> m_tdata[ipv4hp_pkg::OUT_TDATA_W-1:3] == '0)
        else $error("rejected packet carries field data");

    // A fresh result follows a last word accepted through the byte stage into the result register.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) && $past(aresetn, 2) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a preceding last word");

    // With the result register empty the input side never stalls.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind ipv4_header_parser_core ipv4hp_checker u_ipv4hp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
